FILE: rtl/sgm_pkg.sv
// Shared constants and item types for the Sobel gradient magnitude block.
// No dependencies; every other file but sgm_ram imports this package.
`timescale 1ns / 1ps

package sgm_pkg;

  // Image geometry
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int MIN_DIM      = 3;
  localparam int POS_W        = 11;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Queue between front and back
  localparam int MQ_DEPTH = 4;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

  // Result queue in the back part
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       magnitude;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             frame_last;
  } out_item_t;

  // Scaled gradients and tags of one full window
  typedef struct packed {
    logic signed [8:0] gx;
    logic signed [8:0] gy;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last;
  } grad_item_t;

  typedef struct packed {
    logic       valid;
    grad_item_t item;
  } grad_push_t;

  typedef struct packed {
    logic                valid;
    logic [MQ_CNT_W-1:0] count;
  } mq_stat_t;

endpackage

FILE: rtl/sobel_gradient_magnitude.sv
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_front, sgm_queue and sgm_back.
`timescale 1ns / 1ps

// Gray pixels are pushed in raster order, one per clock when in_full stays low;
// a pixel with frame_start set is row 0, column 0 of a new frame. Every pixel
// that completes a 3x3 window inside the image gives one result: the floor
// square root of the squared, quarter-scaled Sobel gradients, saturated at 255,
// with the window centre's row and column, and frame_last on the final window
// of the frame. Border pixels give nothing. Sustained rate is one pixel per
// cycle while in_full stays low; a result passes through the registered
// line-store read, the gradient queue, the squaring and the two-stage square
// root pipeline. No clearing pass runs after reset: the line stores are filled
// by the first two rows of a frame. Write image_width (index 0) and
// image_height (index 1) only while the block is idle; values outside 3..2048
// act as the nearest limit.
module sobel_gradient_magnitude (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  sgm_pkg::in_item_t             in_item,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output sgm_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_data
);
  import sgm_pkg::*;

  grad_push_t grad_push;
  grad_item_t mq_head;
  mq_stat_t   mq_stat;
  logic       mq_pop;

  // Front: position, line stores, window, gradients
  sgm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_stat   (mq_stat),
    .grad_push (grad_push)
  );

  // Gradient item queue
  sgm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .grad_push (grad_push),
    .pop       (mq_pop),
    .head      (mq_head),
    .mq_stat   (mq_stat)
  );

  // Back: magnitude and result queue
  sgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mq_stat   (mq_stat),
    .head      (mq_head),
    .mq_pop    (mq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(grad_push.valid && (mq_stat.count == MQ_CNT_W'(MQ_DEPTH)) && !mq_pop))
    else $error("gradient queue overflow");

  // The back only pops a queue that holds an item
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    mq_pop |-> mq_stat.valid)
    else $error("gradient queue underflow");

  // A full gradient queue holds off new pixels
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (mq_stat.count == MQ_CNT_W'(MQ_DEPTH)) |-> in_full)
    else $error("pixel taken while gradient queue full");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");
`endif

endmodule

FILE: rtl/sgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/sgm_front.sv
// Front part: configuration registers, raster position, line stores, 3x3 window
// and scaled Sobel sums. Depends on sgm_pkg and sgm_ram.
`timescale 1ns / 1ps

module sgm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  sgm_pkg::in_item_t             in_item,
  output logic                          in_full,
  input  logic                          cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_data,
  input  sgm_pkg::mq_stat_t             mq_stat,
  output sgm_pkg::grad_push_t           grad_push
);
  import sgm_pkg::*;

  localparam int CR_W = MQ_CNT_W + 1;

  logic [CFG_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] w_eff, h_eff;

  logic             accept;
  logic [POS_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [POS_W-1:0] cur_col, cur_row;
  logic [CFG_W-1:0] col_ext, row_ext;
  logic             produce, last;

  // Stage A: item whose line-store read is in flight
  logic             a_valid_r, a_produce_r, a_last_r, a_fwd_r;
  logic [POS_W-1:0] a_col_r, a_orow_r, a_ocol_r;
  logic [7:0]       a_px_r, fwd_top_r, fwd_mid_r;

  logic [7:0] up_rdata, mid_rdata, top_b, mid_b;
  logic [7:0] win_r [6];

  logic [9:0]         left_s, right_s, bot_s, upper_s;
  logic signed [10:0] gx_full, gy_full;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    if (v < CFG_W'(MIN_DIM)) begin
      return CFG_W'(MIN_DIM);
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Divide by four, rounding toward zero
  function automatic logic signed [8:0] div4(input logic signed [10:0] v);
    logic signed [10:0] t;
    t = v + (v[10] ? 11'sd3 : 11'sd0);
    return t[10:2];
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_dim(width_r, CFG_W'(MAX_WIDTH));
  assign h_eff = clamp_dim(height_r, CFG_W'(HEIGHT_LIMIT));

  // Room check: the item in stage A may still push into the queue
  assign in_full = ({1'b0, mq_stat.count} + CR_W'(a_valid_r)) >= CR_W'(MQ_DEPTH);
  assign accept  = in_push && !in_full;

  // Position of this pixel and whether its window is complete
  always_comb begin
    cur_col = in_item.frame_start ? '0 : col_r;
    cur_row = in_item.frame_start ? '0 : row_r;
    col_ext = {1'b0, cur_col};
    row_ext = {1'b0, cur_row};
    produce = (row_ext >= CFG_W'(2)) && (col_ext >= CFG_W'(2)) &&
              (row_ext < h_eff) && (col_ext < w_eff);
    last    = (row_ext == h_eff - CFG_W'(1)) && (col_ext == w_eff - CFG_W'(1));
    col_nxt = cur_col + POS_W'(1);
    row_nxt = cur_row;
    if (col_ext + CFG_W'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_ext + CFG_W'(1) >= h_eff) ? '0 : cur_row + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // Stage A payload; forward when the line-store entry is still being written
  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r     <= cur_col;
      a_px_r      <= in_item.pixel;
      a_produce_r <= produce;
      a_last_r    <= last;
      a_orow_r    <= cur_row - POS_W'(1);
      a_ocol_r    <= cur_col - POS_W'(1);
      a_fwd_r     <= a_valid_r && (cur_col == a_col_r);
      fwd_top_r   <= mid_b;
      fwd_mid_r   <= a_px_r;
    end
  end

  // Line stores: upper row and middle row
  sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (a_valid_r),
    .waddr (a_col_r),
    .wdata (mid_b),
    .re    (accept),
    .raddr (cur_col),
    .rdata (up_rdata)
  );

  sgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (a_valid_r),
    .waddr (a_col_r),
    .wdata (a_px_r),
    .re    (accept),
    .raddr (cur_col),
    .rdata (mid_rdata)
  );

  assign top_b = a_fwd_r ? fwd_top_r : up_rdata;
  assign mid_b = a_fwd_r ? fwd_mid_r : mid_rdata;

  // Window: two older columns, shifted on each item
  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_b;
      win_r[4] <= mid_b;
      win_r[5] <= a_px_r;
    end
  end

  // Sobel sums with row and column weights 1,2,1
  always_comb begin
    left_s  = {2'b0, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b0, win_r[2]};
    right_s = {2'b0, top_b} + {1'b0, mid_b, 1'b0} + {2'b0, a_px_r};
    bot_s   = {2'b0, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b0, a_px_r};
    upper_s = {2'b0, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b0, top_b};
    gx_full = $signed({1'b0, left_s}) - $signed({1'b0, right_s});
    gy_full = $signed({1'b0, bot_s}) - $signed({1'b0, upper_s});
  end

  always_comb begin
    grad_push.valid     = a_valid_r && a_produce_r;
    grad_push.item.gx   = div4(gx_full);
    grad_push.item.gy   = div4(gy_full);
    grad_push.item.row  = a_orow_r;
    grad_push.item.col  = a_ocol_r;
    grad_push.item.last = a_last_r;
  end

endmodule

FILE: rtl/sgm_queue.sv
// Short queue of gradient items between the front and back parts.
// Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  sgm_pkg::grad_push_t grad_push,
  input  logic                pop,
  output sgm_pkg::grad_item_t head,
  output sgm_pkg::mq_stat_t   mq_stat
);
  import sgm_pkg::*;

  grad_item_t          mem_r [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [MQ_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (grad_push.valid && !pop) begin
      count_nxt = count_r + MQ_CNT_W'(1);
    end else if (!grad_push.valid && pop) begin
      count_nxt = count_r - MQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (grad_push.valid) begin
        wr_ptr_r <= wr_ptr_r + MQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + MQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grad_push.valid) begin
      mem_r[wr_ptr_r] <= grad_push.item;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign mq_stat.valid = (count_r != '0);
  assign mq_stat.count = count_r;

endmodule

FILE: rtl/sgm_back.sv
// Back part: squares, saturated integer square root over two stages, and the
// result queue. Depends on sgm_pkg.
`timescale 1ns / 1ps

module sgm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sgm_pkg::mq_stat_t   mq_stat,
  input  sgm_pkg::grad_item_t head,
  output logic                mq_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output sgm_pkg::out_item_t  out_item
);
  import sgm_pkg::*;

  // Above this sum the root is at least 255
  localparam logic [15:0] SQ_SAT = 16'd65025;
  localparam logic [15:0] BIT_HI = 16'h4000;
  localparam logic [15:0] BIT_LO = 16'h0040;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
  } sq_state_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

  logic        take;
  logic [OQ_CNT_W-1:0] in_flight;

  logic        p1_v_r, p2_v_r, p3_v_r;
  tag_t        p1_tag_r, p2_tag_r, p3_tag_r;
  logic [15:0] sqx_r, sqy_r, sum_r;
  sq_state_t   p3_st_r, st_a, st_b;
  logic [8:0]  ax9, ay9;
  logic [16:0] sum_full;

  out_item_t           oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_r, oq_rd_r;
  logic [OQ_CNT_W-1:0] oq_count_r, oq_count_nxt;
  logic                oq_pop;

  // One restoring square root step
  function automatic sq_state_t sqrt_step(input sq_state_t s, input logic [15:0] b);
    logic [16:0] trial;
    sq_state_t   r;
    trial = {1'b0, s.root} + {1'b0, b};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[15:0];
      r.root = (s.root >> 1) + b;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // Take an item only when its result is sure to find room
  assign in_flight = OQ_CNT_W'(p1_v_r) + OQ_CNT_W'(p2_v_r) + OQ_CNT_W'(p3_v_r);
  assign take      = mq_stat.valid && ((oq_count_r + in_flight) < OQ_CNT_W'(OQ_DEPTH));
  assign mq_pop    = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= take;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // Stage 1: squares of the absolute gradients
  assign ax9 = head.gx[8] ? (~head.gx + 9'sd1) : head.gx;
  assign ay9 = head.gy[8] ? (~head.gy + 9'sd1) : head.gy;

  always_ff @(posedge clk) begin
    if (take) begin
      sqx_r    <= ax9[7:0] * ax9[7:0];
      sqy_r    <= ay9[7:0] * ay9[7:0];
      p1_tag_r <= '{row: head.row, col: head.col, last: head.last};
    end
  end

  // Stage 2: sum, clamped where the root saturates
  assign sum_full = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    sum_r    <= (sum_full > {1'b0, SQ_SAT}) ? SQ_SAT : sum_full[15:0];
    p2_tag_r <= p1_tag_r;
  end

  // Stage 3: upper four root bits
  always_comb begin
    st_a.rem  = sum_r;
    st_a.root = '0;
    for (int i = 0; i < 4; i++) begin
      st_a = sqrt_step(st_a, BIT_HI >> (2 * i));
    end
  end

  always_ff @(posedge clk) begin
    p3_st_r  <= st_a;
    p3_tag_r <= p2_tag_r;
  end

  // Lower four root bits, written straight into the result queue
  always_comb begin
    st_b = p3_st_r;
    for (int i = 0; i < 4; i++) begin
      st_b = sqrt_step(st_b, BIT_LO >> (2 * i));
    end
  end

  // Result queue
  assign oq_pop = out_pop && !out_empty;

  always_comb begin
    oq_count_nxt = oq_count_r;
    if (p3_v_r && !oq_pop) begin
      oq_count_nxt = oq_count_r + OQ_CNT_W'(1);
    end else if (!p3_v_r && oq_pop) begin
      oq_count_nxt = oq_count_r - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      oq_count_r <= oq_count_nxt;
      if (p3_v_r) begin
        oq_wr_r <= oq_wr_r + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p3_v_r) begin
      oq_r[oq_wr_r] <= '{magnitude:  st_b.root[7:0],
                         center_row: p3_tag_r.row,
                         center_col: p3_tag_r.col,
                         frame_last: p3_tag_r.last};
    end
  end

  assign out_empty = (oq_count_r == '0);
  assign out_item  = oq_r[oq_rd_r];

endmodule

FILE: tb/sobel_gradient_magnitude_test.sv
// Self-checking testbench for sobel_gradient_magnitude: random and directed pixel
// streams, a scoreboard that predicts each magnitude and checks it on the result side.
// Depends on sgm_pkg and the RTL of sobel_gradient_magnitude.
`timescale 1ns / 1ps

module sobel_gradient_magnitude_test;
  import sgm_pkg::*;

  localparam int SETTLE_CYCLES = 12;    // covers the pipeline with margin
  localparam int STALL_LIMIT   = 2000;  // cycles with no item moving either way
  localparam int REPORT_CAP    = 40;

  // Predicts the Sobel magnitude of each pixel and checks results in order
  class magnitude_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [7:0]       line_upper [MAX_WIDTH];
    logic [7:0]       line_middle [MAX_WIDTH];
    logic [7:0]       window [6];
    int unsigned      col;
    int unsigned      row;
    out_item_t        expected_mags [$];
    int unsigned      pixels;
    int unsigned      results;
    int unsigned      frame_ends;
    int unsigned      errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (line_upper[i]) begin
        line_upper[i]  = '0;
        line_middle[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col        = 0;
      row        = 0;
      pixels     = 0;
      results    = 0;
      frame_ends = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        CFG_IMAGE_WIDTH: begin
          width_reg = data;
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data;
        end
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    // Bitwise search; the sum of squares never exceeds 2 * 255 * 255
    function int unsigned floor_root(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = 9; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function int unsigned pending();
      return expected_mags.size();
    endfunction

    // One accepted pixel: update line stores and window, queue any result
    function void note_pixel(in_item_t it);
      int unsigned w, h, c, r, mag;
      int          px, top, mid, gx, gy;
      out_item_t   res;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, HEIGHT_LIMIT);
      px  = it.pixel;
      top = 0;
      mid = 0;
      pixels++;
      if (it.frame_start) begin
        col = 0;
        row = 0;
      end
      c = col;
      r = row;
      if (c < MAX_WIDTH) begin
        top            = line_upper[c];
        mid            = line_middle[c];
        line_upper[c]  = mid[7:0];
        line_middle[c] = it.pixel;
      end
      // full window inside the image: left minus right, bottom minus top
      if (r >= 2 && c >= 2 && r < h && c < w) begin
        gx = (int'(window[0]) + 2 * int'(window[1]) + int'(window[2]))
             - (top + 2 * mid + px);
        gy = (int'(window[2]) + 2 * int'(window[5]) + px)
             - (int'(window[0]) + 2 * int'(window[3]) + top);
        gx = gx / 4;  // truncates toward zero
        gy = gy / 4;
        mag = floor_root(gx * gx + gy * gy);
        if (mag > 255) mag = 255;
        res.magnitude  = mag[7:0];
        res.center_row = POS_W'(r - 1);
        res.center_col = POS_W'(c - 1);
        res.frame_last = (r == h - 1) && (c == w - 1);
        expected_mags.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top[7:0];
      window[4] = mid[7:0];
      window[5] = it.pixel;
      // raster advance; a position beyond a shrunk geometry wraps here too
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void report(string field, out_item_t want, int unsigned exp_v,
                         int unsigned got_v);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch at centre (%0d,%0d): expected %0d, actual %0d",
                 $time, field, want.center_row, want.center_col, exp_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_mags.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result: expected none, actual mag %0d at (%0d,%0d)",
                   $time, got.magnitude, got.center_row, got.center_col);
        return;
      end
      want = expected_mags.pop_front();
      results++;
      if (want.frame_last) frame_ends++;
      if (got.magnitude !== want.magnitude)
        report("magnitude", want, want.magnitude, got.magnitude);
      if (got.center_row !== want.center_row)
        report("center_row", want, want.center_row, got.center_row);
      if (got.center_col !== want.center_col)
        report("center_col", want, want.center_col, got.center_col);
      if (got.frame_last !== want.frame_last)
        report("frame_last", want, want.frame_last, got.frame_last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  in_item_t             in_item   = '0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  magnitude_scoreboard mag_sb;
  int                  send_idle    = 0;  // percent of cycles the sender holds back
  int                  recv_idle    = 0;  // percent of cycles the receiver stalls
  logic [7:0]          pixel_base   = 8'd128;
  int unsigned         quiet_cycles = 0;

  sobel_gradient_magnitude uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check on acceptance, then choose whether to stall
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) mag_sb.check_result(out_item);
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("sobel_gradient_magnitude_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mix of flat, noisy and full-swing pixels
  function automatic logic [7:0] next_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 50) begin
      // gentle slope keeps gradients small, where truncation shows
      pixel_base = pixel_base + 8'($urandom_range(6)) - 8'd3;
      return pixel_base;
    end
    return 8'($urandom);
  endfunction

  task automatic push_pixel(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    mag_sb.note_pixel(it);
  endtask

  // Wait for every outstanding result, then let border pixels clear the pipeline
  task automatic drain();
    while (mag_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_geometry(int unsigned w, int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    mag_sb.set_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    mag_sb.set_reg(CFG_IMAGE_HEIGHT, CFG_W'(h));
    cfg_we <= 1'b0;
  endtask

  // restart: frame_start on the first item; stray: occasional frame restarts
  task automatic send_stream(int count, bit restart, bit stray);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      // now and then hold the sender until the output has caught up
      if (i != 0 && $urandom_range(199) == 0) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (mag_sb.pending() != 0) @(posedge clk);
      end
      it.pixel       = next_pixel();
      it.frame_start = (i == 0) ? restart : (stray && $urandom_range(149) == 0);
      push_pixel(it);
    end
    in_push <= 1'b0;
  endtask

  // Small frame, sometimes with a dimension below the minimum
  task automatic random_small_phase();
    int unsigned w, h;
    w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
    h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
    program_geometry(w, h);
    send_stream($urandom_range(20, 80), 1'b1, 1'b1);
    drain();
  endtask

  initial begin
    logic [7:0] edge_pattern [29];
    in_item_t   it;

    // 3x3 frames: strong left edge, saturating corner (wrapped in without
    // frame_start), then two stray pixels cut short by a restart and a
    // faint corner that survives truncation
    edge_pattern = '{
      255, 0, 0, 255, 0, 0, 255, 0, 0,
      255, 0, 0, 255, 0, 0, 255, 255, 255,
      77, 200,
      0, 0, 0, 0, 0, 0, 0, 0, 5
    };

    mag_sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 7;
    recv_idle = 52;

    // reset geometry 640 x 480: part of the first row, which gives nothing
    send_stream(24, 1'b0, 1'b0);
    drain();

    program_geometry(3, 3);
    for (int i = 0; i < 29; i++) begin
      it.pixel       = edge_pattern[i];
      it.frame_start = (i == 0 || i == 20);
      push_pixel(it);
    end
    in_push <= 1'b0;
    drain();

    repeat (4) random_small_phase();
    // medium frame, one full frame plus the start of the next
    program_geometry(16, 6);
    send_stream(16 * 6 + 3, 1'b1, 1'b0);
    drain();

    send_idle = 52;
    recv_idle = 7;
    repeat (4) random_small_phase();
    // width above range with height below it: the first row gives nothing
    program_geometry(4095, 0);
    send_stream(40, 1'b1, 1'b0);
    drain();

    send_idle = 0;
    recv_idle = 0;
    // width shrunk under the current column, then height under the current row
    program_geometry(8, 6);
    send_stream(30, 1'b1, 1'b0);
    drain();
    program_geometry(5, 4);
    send_stream(40, 1'b0, 1'b0);
    drain();
    program_geometry(6, 8);
    send_stream(40, 1'b1, 1'b0);
    drain();
    program_geometry(6, 4);
    send_stream(30, 1'b0, 1'b0);
    drain();
    repeat (3) random_small_phase();

    $display("Streamed %0d pixels, checked %0d magnitudes and %0d frame ends;",
             mag_sb.pixels, mag_sb.results, mag_sb.frame_ends);
    $display("small and medium frames under both stall mixes, clamped, wrapped and resized.");
    if (mag_sb.pending() != 0)
      $display("%0d expected results never arrived", mag_sb.pending());
    if (mag_sb.errors == 0 && mag_sb.pending() == 0) begin
      $display("sobel_gradient_magnitude_test: PASS");
    end else begin
      $display("sobel_gradient_magnitude_test: FAIL");
    end
    $finish;
  end

endmodule
